// ===== hw/rtl/gptw_pkg.sv =====
// Shared types and constants for the guest page table walker.
// No dependencies; used by gptw_step and guest_page_table_walker.
package gptw_pkg;

	localparam int PPN_WIDTH   = 44;
	localparam int INDEX_BITS  = 9;
	localparam int PTE_PPN_POS = 10;
	localparam int CFG_WIDTH   = 44;

	// Entry flag positions
	localparam int PTE_V = 0;
	localparam int PTE_R = 1;
	localparam int PTE_W = 2;
	localparam int PTE_X = 3;

	// Translation modes
	localparam logic [3:0] MODE_OFF   = 4'd0;
	localparam logic [3:0] MODE_THREE = 4'd8;
	localparam logic [3:0] MODE_FOUR  = 4'd9;

	// Request commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_RESP  = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_FAULT = 2'd2;

	// Configuration register indexes
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_ROOT = 1'b1;

	typedef struct packed {
		logic        command;
		logic [63:0] virt_addr;
		logic [63:0] entry_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] out_address;
	} out_item_t;

	typedef struct packed {
		logic        walking;
		logic [1:0]  level;
		logic [63:0] va;
	} walk_state_t;

endpackage

// ===== hw/rtl/guest_page_table_walker.sv =====
// Guest page table walker, top level: configuration registers, walk state
// and output register. Depends on gptw_pkg and gptw_step.
//
// Translates guest virtual addresses through an Sv39 (mode 8) or Sv48
// (mode 9) page table; mode 0 passes the address through and any other mode
// faults. The block never reads memory itself: each table access leaves as a
// read result carrying the entry address, and the caller returns the 8-byte
// entry as a response request. A request is taken every cycle that the output
// register is empty or being drained, and its result, if any, appears in the
// cycle after acceptance; the single output register is the only limit on
// throughput. Starts during a walk and responses while idle are dropped
// without a result. Write the mode and root page number only while no walk
// is in progress.
module guest_page_table_walker #(
	parameter int PAGE_OFFSET_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gptw_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gptw_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [gptw_pkg::CFG_WIDTH-1:0] cfg_data
);

	logic [3:0]                     mode_q;
	logic [gptw_pkg::PPN_WIDTH-1:0] root_q;
	gptw_pkg::walk_state_t          state_q;
	gptw_pkg::walk_state_t          state_nxt;
	logic                           step_emit;
	gptw_pkg::out_item_t            step_res;
	logic                           out_valid_q;
	gptw_pkg::out_item_t            out_item_q;
	logic                           accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	gptw_step #(
		.PAGE_OFFSET_BITS(PAGE_OFFSET_BITS)
	) u_step (
		.req  (in_item),
		.cur  (state_q),
		.mode (mode_q),
		.root (root_q),
		.nxt  (state_nxt),
		.emit (step_emit),
		.res  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gptw_pkg::MODE_OFF;
			root_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gptw_pkg::REG_MODE: mode_q <= cfg_data[3:0];
				gptw_pkg::REG_ROOT: root_q <= cfg_data[gptw_pkg::PPN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && step_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && step_emit) begin
			out_item_q <= step_res;
		end
	end

`ifndef SYNTHESIS
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.result_kind == gptw_pkg::KIND_READ
			|| out_item.result_kind == gptw_pkg::KIND_DONE
			|| out_item.result_kind == gptw_pkg::KIND_FAULT))
		else $error("illegal result kind");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.result_kind == gptw_pkg::KIND_FAULT |-> out_item.out_address == '0)
		else $error("fault with nonzero address");

	a_read_walks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step_emit && step_res.result_kind == gptw_pkg::KIND_READ |=> state_q.walking)
		else $error("read issued without an active walk");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step_emit && step_res.result_kind != gptw_pkg::KIND_READ |=> !state_q.walking)
		else $error("walk still active after done or fault");

	a_idle_resp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.command == gptw_pkg::CMD_RESP && !state_q.walking && out_ready
		|=> !out_valid)
		else $error("result produced for a response while idle");
`endif

endmodule

// ===== hw/rtl/gptw_step.sv =====
// One walk step: decodes a request against the current walk state and
// produces the next state and an optional result. Depends on gptw_pkg.
module gptw_step #(
	parameter int PAGE_OFFSET_BITS = 12
) (
	input  gptw_pkg::in_item_t    req,
	input  gptw_pkg::walk_state_t cur,
	input  logic [3:0]            mode,
	input  logic [gptw_pkg::PPN_WIDTH-1:0] root,
	output gptw_pkg::walk_state_t nxt,
	output logic                  emit,
	output gptw_pkg::out_item_t   res
);

	function automatic logic [63:0] entry_addr(input logic [gptw_pkg::PPN_WIDTH-1:0] page,
			input logic [1:0] lvl, input logic [63:0] va);
		logic [gptw_pkg::INDEX_BITS-1:0] idx;
		case (lvl)
			2'd0: idx = va[PAGE_OFFSET_BITS +: gptw_pkg::INDEX_BITS];
			2'd1: idx = va[PAGE_OFFSET_BITS + gptw_pkg::INDEX_BITS +: gptw_pkg::INDEX_BITS];
			2'd2: idx = va[PAGE_OFFSET_BITS + 2*gptw_pkg::INDEX_BITS +: gptw_pkg::INDEX_BITS];
			default: idx = va[PAGE_OFFSET_BITS + 3*gptw_pkg::INDEX_BITS +: gptw_pkg::INDEX_BITS];
		endcase
		return (64'(page) << PAGE_OFFSET_BITS) + (64'(idx) << 3);
	endfunction

	function automatic logic [63:0] off_mask(input logic [1:0] lvl);
		logic [63:0] m;
		case (lvl)
			2'd0: m = (64'(1) << PAGE_OFFSET_BITS) - 64'(1);
			2'd1: m = (64'(1) << (PAGE_OFFSET_BITS + gptw_pkg::INDEX_BITS)) - 64'(1);
			2'd2: m = (64'(1) << (PAGE_OFFSET_BITS + 2*gptw_pkg::INDEX_BITS)) - 64'(1);
			default: m = (64'(1) << (PAGE_OFFSET_BITS + 3*gptw_pkg::INDEX_BITS)) - 64'(1);
		endcase
		return m;
	endfunction

	logic [gptw_pkg::PPN_WIDTH-1:0] pte_page;
	logic                           pte_bad;
	logic                           pte_leaf;
	logic [1:0]                     lvl_down;

	assign pte_page = req.entry_word[gptw_pkg::PTE_PPN_POS +: gptw_pkg::PPN_WIDTH];
	assign pte_bad  = !req.entry_word[gptw_pkg::PTE_V]
		|| (req.entry_word[gptw_pkg::PTE_W] && !req.entry_word[gptw_pkg::PTE_R]);
	assign pte_leaf = req.entry_word[gptw_pkg::PTE_R] || req.entry_word[gptw_pkg::PTE_X];
	assign lvl_down = cur.level - 2'd1;

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;
		if (req.command == gptw_pkg::CMD_START) begin
			// a start during a walk is dropped
			if (!cur.walking) begin
				emit = 1'b1;
				case (mode)
					gptw_pkg::MODE_OFF: begin
						res.result_kind = gptw_pkg::KIND_DONE;
						res.out_address = req.virt_addr;
					end
					gptw_pkg::MODE_THREE, gptw_pkg::MODE_FOUR: begin
						nxt.walking = 1'b1;
						nxt.level   = (mode == gptw_pkg::MODE_THREE) ? 2'd2 : 2'd3;
						nxt.va      = req.virt_addr;
						res.result_kind = gptw_pkg::KIND_READ;
						res.out_address = entry_addr(root, nxt.level, req.virt_addr);
					end
					default: begin
						res.result_kind = gptw_pkg::KIND_FAULT;
					end
				endcase
			end
		end else if (cur.walking) begin
			emit = 1'b1;
			if (pte_bad) begin
				nxt.walking = 1'b0;
				res.result_kind = gptw_pkg::KIND_FAULT;
			end else if (pte_leaf) begin
				nxt.walking = 1'b0;
				res.result_kind = gptw_pkg::KIND_DONE;
				res.out_address = (64'(pte_page) << PAGE_OFFSET_BITS)
					| (cur.va & off_mask(cur.level));
			end else if (cur.level == 2'd0) begin
				// pointer entry with no level left below
				nxt.walking = 1'b0;
				res.result_kind = gptw_pkg::KIND_FAULT;
			end else begin
				nxt.level = lvl_down;
				res.result_kind = gptw_pkg::KIND_READ;
				res.out_address = entry_addr(pte_page, lvl_down, cur.va);
			end
		end
	end

endmodule
